/* src/maf_pkg.sv */
// ----------------------------------------------------------------------------
// maf_pkg: shared types and constants for the moving average filter
// Field widths, stream packing, controller states and the command/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package maf_pkg;

    localparam int TIME_W     = 63;
    localparam int PRICE_W    = 40;
    localparam int WLEN_W     = 7;
    localparam int TDATA_W    = 104;
    localparam int PRICE_LSB  = TIME_W;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd20;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CHECK = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_SUB   = 7'b0001000,
        ST_WRITE = 7'b0010000,
        ST_PREP  = 7'b0100000,
        ST_DIV   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic take_in;
        logic read_old;
        logic sub_old;
        logic write_new;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic len_zero;
        logic full;
        logic win_valid;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

/* src/moving_average_filter.sv */
// ----------------------------------------------------------------------------
// moving_average_filter: simple moving average over price bars
// Keeps the last window_length closes (at most MAX_WINDOW) and their running sum;
// per bar it emits time, truncated mean, window-full flag (nothing at length 0).
// ----------------------------------------------------------------------------
//  channel   | dir | tdata (low bit up)                      | tuser
//  ----------+-----+-----------------------------------------+--------------
//  s_axis    | in  | bar_time[62:0], bar_close[102:63]       | start_series
//  m_axis    | out | out_time[62:0], average[102:63]         | average_valid
//  cfg       | in  | cfg_wdata = window_length, write on cfg_we
//
//  One bar at a time. With a full window the result comes from the bit-serial
//  divider over the SUM_W-bit running sum; the bar that fills the window
//  skips the eviction of the oldest close, and while the window is still
//  filling the division steps are skipped.
//  Reset: window length 20, empty window; no store clearing pass.
//  A result waits in the output register; the next bar is taken meanwhile
//  and its result is held until the pending one transfers.
// ----------------------------------------------------------------------------
module moving_average_filter
#(
    parameter int MAX_WINDOW = 64
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [maf_pkg::WLEN_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [maf_pkg::TDATA_W-1:0] s_tdata,   // bar_time, bar_close, pad
    input  logic                        s_tuser,   // start_series
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [maf_pkg::TDATA_W-1:0] m_tdata,   // out_time, average, pad
    output logic                        m_tuser    // average_valid
);

    maf_pkg::cmd_t    cmd;
    maf_pkg::status_t status;

    maf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    maf_datapath
    #(
        .MAX_WINDOW (MAX_WINDOW)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* src/maf_ctrl.sv */
// ----------------------------------------------------------------------------
// maf_ctrl: sequencer for the moving average filter
// Steps one bar at a time through capture, eviction of the oldest sample once
// the window is full, insertion of the new one and, with a full window, the
// serial division; it hands each result to the output register.
// ----------------------------------------------------------------------------
module maf_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  maf_pkg::status_t status,
    output maf_pkg::cmd_t    cmd
);

    maf_pkg::state_t state_reg;
    maf_pkg::state_t state_next;
    logic            done_reg;
    logic            done_next;

    // done_reg: the divider has finished and the result waits for the output stage
    always_comb
    begin
        state_next = state_reg;
        done_next  = done_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            maf_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.take_in = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = maf_pkg::ST_CHECK;
                end
            end
            maf_pkg::ST_CHECK:
            begin
                if (status.len_zero)
                begin
                    state_next = maf_pkg::ST_IDLE;
                end
                else if (status.full)
                begin
                    state_next = maf_pkg::ST_READ;
                end
                else
                begin
                    state_next = maf_pkg::ST_WRITE;
                end
            end
            maf_pkg::ST_READ:
            begin
                cmd.read_old = 1'b1;
                state_next   = maf_pkg::ST_SUB;
            end
            maf_pkg::ST_SUB:
            begin
                cmd.sub_old = 1'b1;
                state_next  = maf_pkg::ST_WRITE;
            end
            maf_pkg::ST_WRITE:
            begin
                cmd.write_new = 1'b1;
                state_next    = maf_pkg::ST_PREP;
            end
            maf_pkg::ST_PREP:
            begin
                cmd.div_load = 1'b1;
                done_next    = 1'b0;
                state_next   = maf_pkg::ST_DIV;
            end
            maf_pkg::ST_DIV:
            begin
                // without a full window the quotient is unused; skip the steps
                if (!done_reg && status.win_valid)
                begin
                    cmd.div_step = 1'b1;
                    if (status.div_last)
                    begin
                        done_next = 1'b1;
                    end
                end
                else if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = maf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = maf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= maf_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

/* src/maf_datapath.sv */
// ----------------------------------------------------------------------------
// maf_datapath: sample store, running sum, serial divider, output register
// Holds the window length register, the circular store of closes, the
// running sum and a restoring divider that retires one quotient bit a cycle.
// ----------------------------------------------------------------------------
module maf_datapath
#(
    parameter int MAX_WINDOW = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [maf_pkg::WLEN_W-1:0]          cfg_wdata,
    input  logic [maf_pkg::TDATA_W-1:0]         s_tdata,
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [maf_pkg::TDATA_W-1:0]         m_tdata,
    output logic                                m_tuser,
    input  maf_pkg::cmd_t                       cmd,
    output maf_pkg::status_t                    status
);

    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int IDX_W = PTR_W + 1;
    localparam int SUM_W = maf_pkg::PRICE_W + $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(SUM_W + 1);
    localparam int CAP   = (MAX_WINDOW > 127) ? 127 : MAX_WINDOW;

    localparam logic [maf_pkg::WLEN_W-1:0] CAP_LEN  = maf_pkg::WLEN_W'(CAP);
    localparam logic [IDX_W-1:0]           MAX_IDX  = IDX_W'(MAX_WINDOW);
    localparam logic [PTR_W-1:0]           LAST_PTR = PTR_W'(MAX_WINDOW - 1);
    localparam logic [CNT_W-1:0]           DIV_CNT  = CNT_W'(SUM_W);

    logic [maf_pkg::WLEN_W-1:0]  wlen_reg;
    logic [maf_pkg::WLEN_W-1:0]  fill_reg;
    logic [PTR_W-1:0]            slot_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic                        win_valid_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        m_valid_reg;

    logic [maf_pkg::TIME_W-1:0]  time_reg;
    logic [maf_pkg::PRICE_W-1:0] price_reg;
    logic [maf_pkg::PRICE_W-1:0] rdata_reg;
    logic [SUM_W-1:0]            dvd_reg;
    logic [maf_pkg::WLEN_W-1:0]  rem_reg;
    logic [maf_pkg::TIME_W-1:0]  out_time_reg;
    logic [maf_pkg::PRICE_W-1:0] out_avg_reg;
    logic                        out_flag_reg;

    logic [maf_pkg::PRICE_W-1:0] store_mem [0:MAX_WINDOW-1];

    logic [maf_pkg::WLEN_W-1:0]  len_eff;
    logic                        full;
    logic [IDX_W-1:0]            slot_ext;
    logic [IDX_W-1:0]            len_ext;
    logic [IDX_W-1:0]            old_idx;
    logic [PTR_W-1:0]            old_ptr;
    logic [maf_pkg::WLEN_W:0]    trial;
    logic                        qbit;
    logic [maf_pkg::WLEN_W-1:0]  rem_next;

    assign len_eff  = ({1'b0, wlen_reg} > {1'b0, CAP_LEN}) ? CAP_LEN : wlen_reg;
    assign full     = (fill_reg >= len_eff);
    assign slot_ext = IDX_W'(slot_reg);
    assign len_ext  = IDX_W'(len_eff);
    assign old_idx  = (slot_ext >= len_ext) ? (slot_ext - len_ext)
                                            : (slot_ext + MAX_IDX - len_ext);
    assign old_ptr  = old_idx[PTR_W-1:0];

    // one restoring division step
    assign trial    = {rem_reg, dvd_reg[SUM_W-1]};
    assign qbit     = (trial >= {1'b0, len_eff});
    assign rem_next = qbit ? maf_pkg::WLEN_W'(trial - {1'b0, len_eff})
                           : trial[maf_pkg::WLEN_W-1:0];

    assign status.len_zero  = (len_eff == '0);
    assign status.full      = full;
    assign status.win_valid = win_valid_reg;
    assign status.div_last  = (cnt_reg == CNT_W'(1));
    assign status.out_free  = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg      <= maf_pkg::WLEN_RESET;
            fill_reg      <= '0;
            slot_reg      <= '0;
            sum_reg       <= '0;
            win_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wlen_reg <= cfg_wdata;
                fill_reg <= '0;
                slot_reg <= '0;
                sum_reg  <= '0;
            end
            else if (cmd.take_in && s_tuser)
            begin
                fill_reg <= '0;
                slot_reg <= '0;
                sum_reg  <= '0;
            end
            else if (cmd.sub_old)
            begin
                sum_reg <= sum_reg - SUM_W'(rdata_reg);
            end
            else if (cmd.write_new)
            begin
                sum_reg  <= sum_reg + SUM_W'(price_reg);
                slot_reg <= (slot_reg == LAST_PTR) ? '0 : slot_reg + PTR_W'(1);
                if (!full)
                begin
                    fill_reg <= fill_reg + maf_pkg::WLEN_W'(1);
                end
            end

            if (cmd.div_load)
            begin
                win_valid_reg <= (fill_reg == len_eff);
                cnt_reg       <= DIV_CNT;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end

            if (cmd.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            time_reg  <= s_tdata[maf_pkg::TIME_W-1:0];
            price_reg <= s_tdata[maf_pkg::PRICE_LSB +: maf_pkg::PRICE_W];
        end
        if (cmd.read_old)
        begin
            rdata_reg <= store_mem[old_ptr];
        end
        if (cmd.write_new)
        begin
            store_mem[slot_reg] <= price_reg;
        end
        if (cmd.div_load)
        begin
            dvd_reg <= sum_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[SUM_W-2:0], qbit};
            rem_reg <= rem_next;
        end
        if (cmd.out_load)
        begin
            out_time_reg <= time_reg;
            out_avg_reg  <= win_valid_reg ? dvd_reg[maf_pkg::PRICE_W-1:0] : '0;
            out_flag_reg <= win_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_flag_reg;
    assign m_tdata  = {1'b0, out_avg_reg, out_time_reg};

endmodule

/* tb/sv/tb_moving_average_filter.sv */
// ----------------------------------------------------------------------------
// tb_moving_average_filter: self-checking bench for the moving average filter
// Walks a short table of bars and window writes, then random bar series at
// several window lengths and handshake pressure levels. Each output transfer
// is checked against a typed row or an in-bench sliding-window predictor.
// ----------------------------------------------------------------------------
module tb_moving_average_filter;

    localparam int TIME_W    = maf_pkg::TIME_W;
    localparam int PRICE_W   = maf_pkg::PRICE_W;
    localparam int WLEN_W    = maf_pkg::WLEN_W;
    localparam int TDATA_W   = maf_pkg::TDATA_W;
    localparam int PRICE_LSB = maf_pkg::PRICE_LSB;

    localparam int WIN_MAX       = 64;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int NUM_SEGS      = 11;

    localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [PRICE_W-1:0] PRICE_ONE = 40'h00_0001_0000;

    typedef enum {CHK_MODEL, CHK_TYPED, CHK_NONE} row_check_t;

    typedef struct packed {
        logic [TIME_W-1:0]  tm;
        logic [PRICE_W-1:0] avg;
        logic               vld;
    } sma_result_t;

    typedef struct {
        bit                 is_cfg;
        logic [WLEN_W-1:0]  wlen;
        logic [TIME_W-1:0]  tm;
        logic [PRICE_W-1:0] price;
        logic               start;
        row_check_t         chk;
        logic [PRICE_W-1:0] avg;
        logic               vld;
    } bar_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [WLEN_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;   // bar_time, bar_close, pad
    logic                 s_tuser;   // start_series
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;   // out_time, average, pad
    logic                 m_tuser;   // average_valid

    // predictor state
    logic [PRICE_W-1:0]   win_store [WIN_MAX];
    int unsigned          win_slot;
    int unsigned          win_filled;
    logic [45:0]          win_sum;
    logic [WLEN_W-1:0]    win_len;

    sma_result_t          pending_averages [$];
    bar_row_t             bar_table [$];
    int unsigned          mismatches;
    int unsigned          send_idle_pct;
    int unsigned          rcv_stall_pct;
    bit                   hold_req;
    logic [TIME_W-1:0]    bar_clock;

    int seg_wlen [NUM_SEGS] = '{5, 64, 1, 0, 127, 2, 33, 65, 20, 7, 3};
    int seg_bars [NUM_SEGS] = '{50, 140, 40, 25, 140, 40, 80, 100, 60, 40, 30};

    moving_average_filter i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void clear_window();
        win_slot   = 0;
        win_filled = 0;
        win_sum    = '0;
    endfunction

    function automatic bit sma_step(input logic [TIME_W-1:0] tm, input logic [PRICE_W-1:0] price,
                                    input logic start, output sma_result_t r);
        int unsigned n;
        r = '0;
        if (start)
            clear_window();
        n = (win_len > WIN_MAX) ? WIN_MAX : win_len;
        if (n == 0)
            return 1'b0;
        if (win_filled >= n)
        begin
            win_sum    = win_sum - win_store[(win_slot + WIN_MAX - n) % WIN_MAX];
            win_filled = n;
        end
        else
        begin
            win_filled++;
        end
        win_store[win_slot] = price;
        win_sum             = win_sum + price;
        win_slot            = (win_slot + 1) % WIN_MAX;
        r.tm  = tm;
        r.vld = (win_filled == n);
        r.avg = r.vld ? PRICE_W'(win_sum / n) : '0;
        return 1'b1;
    endfunction

    function automatic void add_item(input logic [TIME_W-1:0] tm, input logic [PRICE_W-1:0] price,
                                     input logic start, input row_check_t chk,
                                     input logic [PRICE_W-1:0] avg, input logic vld);
        bar_row_t row;
        row.is_cfg = 1'b0;
        row.wlen   = '0;
        row.tm     = tm;
        row.price  = price;
        row.start  = start;
        row.chk    = chk;
        row.avg    = avg;
        row.vld    = vld;
        bar_table.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [WLEN_W-1:0] wlen);
        bar_row_t row;
        row        = '{default: '0, chk: CHK_NONE};
        row.is_cfg = 1'b1;
        row.wlen   = wlen;
        bar_table.push_back(row);
    endfunction

    task automatic send_bar(input logic [TIME_W-1:0] tm, input logic [PRICE_W-1:0] price,
                            input logic start, input row_check_t chk,
                            input logic [PRICE_W-1:0] avg, input logic vld);
        sma_result_t r;
        bit          got;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, price, tm};
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        got = sma_step(tm, price, start, r);
        case (chk)
            CHK_MODEL:
                if (got)
                    pending_averages.push_back(r);
            CHK_TYPED:
                pending_averages.push_back('{tm: tm, avg: avg, vld: vld});
            default:
                ;
        endcase
    endtask

    // window writes only once the pipeline has drained
    task automatic write_window(input logic [WLEN_W-1:0] wlen);
        s_tvalid <= 1'b0;
        while (pending_averages.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= wlen;
        @(posedge clk);
        cfg_we    <= 1'b0;
        win_len = wlen;
        clear_window();
    endtask

    function automatic logic [PRICE_W-1:0] pick_close(input bit high);
        int unsigned k;
        logic [63:0] raw;
        k   = $urandom_range(99);
        raw = {$urandom, $urandom};
        if (high && k < 60)
            return PRICE_MAX - PRICE_W'($urandom_range(255));
        if (k < 10)
            return PRICE_MAX;
        if (k < 20)
            return '0;
        if (k < 40)
            return PRICE_W'($urandom_range(1 << 20));
        return raw[PRICE_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] pick_bar_time();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if ($urandom_range(99) < 20)
            return raw[TIME_W-1:0];
        bar_clock = bar_clock + 60_000;
        return bar_clock;
    endfunction

    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        sma_result_t exp_r;
        logic [TIME_W-1:0]  got_tm;
        logic [PRICE_W-1:0] got_avg;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_tm  = m_tdata[TIME_W-1:0];
            got_avg = m_tdata[PRICE_LSB +: PRICE_W];
            if (pending_averages.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result time %0d", got_tm));
            end
            else
            begin
                exp_r = pending_averages[0];
                pending_averages.delete(0);
                if (got_tm !== exp_r.tm)
                    report_mismatch($sformatf("out_time %0d, expected %0d", got_tm, exp_r.tm));
                if (got_avg !== exp_r.avg)
                    report_mismatch($sformatf("average %h, expected %h (time %0d)",
                                              got_avg, exp_r.avg, exp_r.tm));
                if (m_tuser !== exp_r.vld)
                    report_mismatch($sformatf("average_valid %b, expected %b (time %0d)",
                                              m_tuser, exp_r.vld, exp_r.tm));
            end
        end
    end

    initial
    begin
        bar_row_t row;
        int       wl;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        mismatches    = 0;
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        hold_req      = 1'b0;
        bar_clock     = 63'd1_700_000_000_000;
        win_len       = maf_pkg::WLEN_RESET;
        clear_window();

        // reset window of 20: nothing valid yet
        add_item(0, 0, 1'b0, CHK_TYPED, 0, 1'b0);
        add_item(TIME_MAX, PRICE_MAX, 1'b1, CHK_TYPED, 0, 1'b0);
        add_item(1000, 123456, 1'b0, CHK_TYPED, 0, 1'b0);
        // window of one: average equals close
        add_cfg(1);
        add_item(5, PRICE_MAX, 1'b0, CHK_TYPED, PRICE_MAX, 1'b1);
        add_item(6, 0, 1'b0, CHK_TYPED, 0, 1'b1);
        add_item(TIME_MAX, PRICE_ONE, 1'b1, CHK_TYPED, PRICE_ONE, 1'b1);
        add_cfg(2);
        add_item(10, PRICE_MAX, 1'b0, CHK_TYPED, 0, 1'b0);
        add_item(11, PRICE_MAX, 1'b0, CHK_TYPED, PRICE_MAX, 1'b1);
        add_item(12, 1, 1'b0, CHK_MODEL, 0, 1'b0);
        add_item(13, 0, 1'b1, CHK_TYPED, 0, 1'b0);
        add_item(14, 3, 1'b0, CHK_MODEL, 0, 1'b0);
        // zero window: no results, start flag still clears
        add_cfg(0);
        add_item(20, 5, 1'b0, CHK_NONE, 0, 1'b0);
        add_item(21, 7, 1'b1, CHK_NONE, 0, 1'b0);
        add_cfg(3);
        add_item(30, PRICE_ONE, 1'b0, CHK_MODEL, 0, 1'b0);
        add_item(31, 2 * PRICE_ONE, 1'b0, CHK_MODEL, 0, 1'b0);
        add_item(32, PRICE_MAX, 1'b0, CHK_MODEL, 0, 1'b0);
        add_item(33, 9, 1'b1, CHK_MODEL, 0, 1'b0);
        add_item(34, PRICE_MAX, 1'b0, CHK_MODEL, 0, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (bar_table[i])
        begin
            row = bar_table[i];
            if (row.is_cfg)
                write_window(row.wlen);
            else
                send_bar(row.tm, row.price, row.start, row.chk, row.avg, row.vld);
        end

        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            wl = seg_wlen[seg];
            write_window(WLEN_W'(wl));
            case (seg % 4)
                0:
                begin
                    send_idle_pct = 0;
                    rcv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 77;
                    rcv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    rcv_stall_pct = 77;
                end
                default:
                begin
                    send_idle_pct = 29;
                    rcv_stall_pct = 29;
                end
            endcase
            // long output back-pressure while bars keep coming
            if (seg == 0)
                hold_req = 1'b1;
            for (int k = 0; k < seg_bars[seg]; k++)
                send_bar(pick_bar_time(), pick_close(wl >= WIN_MAX), $urandom_range(99) < 3,
                         CHK_MODEL, 0, 1'b0);
        end

        s_tvalid <= 1'b0;
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        while (pending_averages.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
